// ===== design/fesc_pkg.sv =====
// ----------------------------------------------------------------------------
// fesc_pkg
// Shared constants, function codes and small control types for the frustum
// plane extraction and sphere cull block.
// ----------------------------------------------------------------------------
`default_nettype none

package fesc_pkg;

  // Default parameter values
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Beat field widths
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned IDX_W  = 4;

  // Storage geometry
  localparam int unsigned MAT_DEPTH   = 16;
  localparam int unsigned N_PLANES    = 6;
  localparam int unsigned N_COMP      = 4;
  localparam int unsigned PLANE_DEPTH = N_PLANES * N_COMP;
  localparam int unsigned PLANE_AW    = $clog2(PLANE_DEPTH);

  // Arithmetic widths
  localparam int unsigned WIDE_W = 64;          // accumulators, radicand, dividend
  localparam int unsigned COMP_W = ELEM_W + 1;  // exact sum of two elements
  localparam int unsigned NRM_W  = ELEM_W - 1;  // normal component after range shift
  localparam int unsigned ROOT_W = ELEM_W;      // floor sqrt of a 64-bit value
  localparam int unsigned LEN_W  = ROOT_W + 2;  // root shifted back by up to 2

  // Function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_EXTRACT = 2'd1,
    FUNC_TEST    = 2'd2
  } func_e;

  // Plane store write control
  typedef struct packed {
    logic                we;
    logic [PLANE_AW-1:0] addr;
  } plane_wr_t;

  // Matrix store write control
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
  } mat_wr_t;

endpackage

`default_nettype wire

// ===== design/fesc_if.sv =====
// ----------------------------------------------------------------------------
// fesc_if
// Valid/ready channels of the frustum cull block: request beats in, result
// beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface fesc_in_if;
  import fesc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [IDX_W-1:0]         element_index;
  logic signed [ELEM_W-1:0] element_value;
  logic signed [ELEM_W-1:0] center_x;
  logic signed [ELEM_W-1:0] center_y;
  logic signed [ELEM_W-1:0] center_z;
  logic signed [ELEM_W-1:0] radius;

  modport source (
    output valid, func, element_index, element_value,
    output center_x, center_y, center_z, radius,
    input  ready
  );

  modport sink (
    input  valid, func, element_index, element_value,
    input  center_x, center_y, center_z, radius,
    output ready
  );
endinterface

interface fesc_out_if;
  import fesc_pkg::*;

  logic              valid;
  logic              ready;
  logic              inside_res;
  logic [FUNC_W-1:0] done_func;

  modport source (output valid, inside_res, done_func, input ready);
  modport sink   (input valid, inside_res, done_func, output ready);
endinterface

`default_nettype wire

// ===== design/fesc_isqrt.sv =====
// ----------------------------------------------------------------------------
// fesc_isqrt
// Iterative floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fesc_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [fesc_pkg::WIDE_W-1:0]   rad_i,
  output logic                          done_o,
  output logic [fesc_pkg::ROOT_W-1:0]   root_o
);
  import fesc_pkg::*;

  logic [WIDE_W-1:0] rem_q, rem_d;
  logic [WIDE_W-1:0] res_q, res_d;
  logic [WIDE_W-1:0] bit_q, bit_d;
  logic [WIDE_W-1:0] trial;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  // One step of the digit-by-digit root
  always_comb begin
    trial  = res_q + bit_q;
    rem_d  = rem_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = rad_i;
      res_d  = '0;
      bit_d  = WIDE_W'(1) << (WIDE_W - 2);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      // the last step runs with the lowest bit
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== design/fesc_div.sv =====
// ----------------------------------------------------------------------------
// fesc_div
// Restoring unsigned divider, 64-bit dividend by a plane length, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fesc_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [fesc_pkg::WIDE_W-1:0]  dividend_i,
  input  logic [fesc_pkg::LEN_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [fesc_pkg::WIDE_W-1:0]  quot_o
);
  import fesc_pkg::*;

  localparam int unsigned CNT_W = $clog2(WIDE_W);

  logic [WIDE_W-1:0] quo_q, quo_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [LEN_W-1:0]  dvs_q, dvs_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W:0]    trial;
  logic [LEN_W:0]    diff;
  logic              ge;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  // Shift in one dividend bit, subtract when it fits
  always_comb begin
    trial  = {rem_q, quo_q[WIDE_W-1]};
    diff   = trial - {1'b0, dvs_q};
    ge     = (trial >= {1'b0, dvs_q});
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
      quo_d = {quo_q[WIDE_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(WIDE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

// ===== design/fesc_extract.sv =====
// ----------------------------------------------------------------------------
// fesc_extract
// Matrix store and plane extraction sequencer: builds each plane from matrix
// columns, forms the normal length and writes the plane (normalized unless zero).
// ----------------------------------------------------------------------------
`default_nettype none

module fesc_extract #(
  parameter int unsigned DATA_WIDTH = fesc_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = fesc_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         near_minus_one_i,
  input  fesc_pkg::mat_wr_t            mat_wr_i,
  input  logic [fesc_pkg::ELEM_W-1:0]  mat_data_i,
  output fesc_pkg::plane_wr_t          pw_o,
  output logic [DATA_WIDTH-1:0]        pw_data_o,
  output logic                         done_o
);
  import fesc_pkg::*;

  localparam logic [WIDE_W-1:0] POS_MAX = (WIDE_W'(1) << (DATA_WIDTH - 1)) - WIDE_W'(1);

  typedef enum logic [6:0] {
    X_IDLE = 7'b0000001,
    X_READ = 7'b0000010,
    X_CAPT = 7'b0000100,
    X_SQ   = 7'b0001000,
    X_ROOT = 7'b0010000,
    X_DINI = 7'b0100000,
    X_DIV  = 7'b1000000
  } xst_e;

  function automatic logic [COMP_W-1:0] mag_c(input logic [COMP_W-1:0] c);
    mag_c = c[COMP_W-1] ? (COMP_W'(0) - c) : c;
  endfunction

  // Signed saturation of a sign and magnitude to the plane width
  function automatic logic [DATA_WIDTH-1:0] sat_mag(input logic neg,
                                                    input logic [WIDE_W-1:0] mag);
    logic [WIDE_W-1:0] neg_v;
    neg_v = WIDE_W'(0) - mag;
    if (neg) begin
      if (mag > POS_MAX) sat_mag = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      else               sat_mag = neg_v[DATA_WIDTH-1:0];
    end else if (mag > POS_MAX) begin
      sat_mag = POS_MAX[DATA_WIDTH-1:0];
    end else begin
      sat_mag = mag[DATA_WIDTH-1:0];
    end
  endfunction

  // Matrix store
  logic [ELEM_W-1:0] mat_mem [MAT_DEPTH];
  logic [ELEM_W-1:0] rd_w_q, rd_e_q;

  xst_e              state_q, state_d;
  logic [2:0]        p_q, p_d;
  logic [1:0]        r_q, r_d;
  logic [1:0]        j_q, j_d;
  logic [1:0]        k_q, k_d;
  logic [1:0]        col;
  logic              cv_q;
  logic [1:0]        cr_q;
  logic [COMP_W-1:0] c_q [N_COMP];
  logic [COMP_W-1:0] w_ext, e_ext, cval;
  logic [COMP_W-1:0] m0, m1, m2, mj, mj_sh, mk;
  logic [1:0]        sh_c, sh_q, sh_d;
  logic [NRM_W-1:0]  ms;
  logic [2*NRM_W-1:0] sq;
  logic [WIDE_W-1:0] s_q, s_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              neg_k;
  logic              root_start, root_done;
  logic [ROOT_W-1:0] root;
  logic              div_start, div_done;
  logic [WIDE_W-1:0] dvd, quot;
  plane_wr_t         pw_q, pw_d;
  logic [DATA_WIDTH-1:0] pwd_q, pwd_d;
  logic              done_q, done_d;
  logic              comp_last;

  // Column paired with w for each plane: left/right x, bottom/top y, near/far z
  always_comb begin
    if (p_q < 3'd2)      col = 2'd0;
    else if (p_q < 3'd4) col = 2'd1;
    else                 col = 2'd2;
  end

  always_ff @(posedge clk_i) begin
    if (mat_wr_i.we) mat_mem[mat_wr_i.addr] <= mat_data_i;
    rd_w_q <= mat_mem[{r_q, 2'd3}];
    rd_e_q <= mat_mem[{r_q, col}];
  end

  // Plane component from the two elements of one row
  always_comb begin
    w_ext = {rd_w_q[ELEM_W-1], rd_w_q};
    e_ext = {rd_e_q[ELEM_W-1], rd_e_q};
    if (p_q == 3'd4 && !near_minus_one_i) cval = e_ext;   // near plane, z >= 0
    else if (p_q[0])                     cval = w_ext - e_ext;
    else                                 cval = w_ext + e_ext;
  end

  // Normal magnitudes and the range shift that keeps squares in 64 bits
  always_comb begin
    m0 = mag_c(c_q[0]);
    m1 = mag_c(c_q[1]);
    m2 = mag_c(c_q[2]);
    if (m0[COMP_W-1] | m1[COMP_W-1] | m2[COMP_W-1])      sh_c = 2'd2;
    else if (m0[COMP_W-2] | m1[COMP_W-2] | m2[COMP_W-2]) sh_c = 2'd1;
    else                                                 sh_c = 2'd0;
    unique case (j_q)
      2'd0:    mj = m0;
      2'd1:    mj = m1;
      default: mj = m2;
    endcase
    mj_sh = mj >> sh_c;
    ms    = mj_sh[NRM_W-1:0];
    sq    = ms * ms;
    mk    = mag_c(c_q[k_q]);
    neg_k = c_q[k_q][COMP_W-1];
    dvd   = (WIDE_W'(mk) << FRAC_BITS) + WIDE_W'(len_q >> 1);
  end

  assign comp_last = (k_q == 2'(N_COMP - 1));

  // Sequencer
  always_comb begin
    state_d    = state_q;
    p_d        = p_q;
    r_d        = r_q;
    j_d        = j_q;
    k_d        = k_q;
    s_d        = s_q;
    sh_d       = sh_q;
    len_d      = len_q;
    pw_d.we    = 1'b0;
    pw_d.addr  = {p_q, k_q};
    pwd_d      = pwd_q;
    done_d     = 1'b0;
    root_start = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      X_IDLE: begin
        if (start_i) begin
          p_d     = '0;
          r_d     = '0;
          state_d = X_READ;
        end
      end
      X_READ: begin
        r_d = r_q + 2'd1;
        if (r_q == 2'd3) state_d = X_CAPT;
      end
      X_CAPT: begin
        j_d     = '0;
        s_d     = '0;
        state_d = X_SQ;
      end
      X_SQ: begin
        j_d = j_q + 2'd1;
        if (j_q == 2'd3) begin
          sh_d       = sh_c;
          root_start = 1'b1;
          state_d    = X_ROOT;
        end else begin
          s_d = s_q + WIDE_W'(sq);
        end
      end
      X_ROOT: begin
        if (root_done) begin
          len_d   = LEN_W'(root) << sh_q;
          k_d     = '0;
          state_d = X_DINI;
        end
      end
      X_DINI: begin
        if (len_q == '0) begin
          // zero normal: plane kept as it is
          pw_d.we = 1'b1;
          pwd_d   = sat_mag(neg_k, WIDE_W'(mk));
        end else begin
          div_start = 1'b1;
          state_d   = X_DIV;
        end
      end
      X_DIV: begin
        if (div_done) begin
          pw_d.we = 1'b1;
          pwd_d   = sat_mag(neg_k, quot);
        end
      end
      default: state_d = X_IDLE;
    endcase

    // Advance to the next component or plane once a component is written
    if (pw_d.we) begin
      if (comp_last) begin
        if (p_q == 3'(N_PLANES - 1)) begin
          done_d  = 1'b1;
          state_d = X_IDLE;
        end else begin
          p_d     = p_q + 3'd1;
          r_d     = '0;
          state_d = X_READ;
        end
      end else begin
        k_d     = k_q + 2'd1;
        state_d = X_DINI;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= X_IDLE;
      p_q     <= '0;
      r_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      cv_q    <= 1'b0;
      pw_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      p_q     <= p_d;
      r_q     <= r_d;
      j_q     <= j_d;
      k_q     <= k_d;
      cv_q    <= (state_q == X_READ);
      pw_q    <= pw_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cr_q  <= r_q;
    s_q   <= s_d;
    sh_q  <= sh_d;
    len_q <= len_d;
    pwd_q <= pwd_d;
    if (cv_q) c_q[cr_q] <= cval;
  end

  fesc_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .rad_i   (s_q),
    .done_o  (root_done),
    .root_o  (root)
  );

  fesc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd),
    .divisor_i  (len_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign pw_o      = pw_q;
  assign pw_data_o = pwd_q;
  assign done_o    = done_q;

  // Sequencer checks
  a_root_in_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_done |-> state_q == X_ROOT) else $error("root result outside root wait");
  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == X_DIV) else $error("quotient outside divide wait");
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_d |-> pw_d.we && pw_d.addr == PLANE_AW'(PLANE_DEPTH - 1))
    else $error("extraction done before last component");

endmodule

`default_nettype wire

// ===== design/fesc_cull.sv =====
// ----------------------------------------------------------------------------
// fesc_cull
// Plane store and sphere test: streams the 24 plane components through a
// pipelined saturating multiply-accumulate and checks each plane distance.
// ----------------------------------------------------------------------------
`default_nettype none

module fesc_cull #(
  parameter int unsigned DATA_WIDTH = fesc_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = fesc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [fesc_pkg::ELEM_W-1:0]  center_x_i,
  input  logic signed [fesc_pkg::ELEM_W-1:0]  center_y_i,
  input  logic signed [fesc_pkg::ELEM_W-1:0]  center_z_i,
  input  logic signed [fesc_pkg::ELEM_W-1:0]  radius_i,
  input  fesc_pkg::plane_wr_t                 pw_i,
  input  logic [DATA_WIDTH-1:0]               pw_data_i,
  output logic                                done_o,
  output logic                                inside_o
);
  import fesc_pkg::*;

  localparam int unsigned HALF_W = WIDE_W / 2;
  localparam int unsigned PROD_W = WIDE_W + HALF_W;
  localparam logic [ELEM_W-1:0] ONE = ELEM_W'(1) << FRAC_BITS;
  localparam logic [PROD_W-1:0] LIM_POS = PROD_W'((WIDE_W'(1) << (WIDE_W - 1)) - WIDE_W'(1));
  localparam logic [PROD_W-1:0] LIM_NEG = PROD_W'(WIDE_W'(1) << (WIDE_W - 1));
  localparam logic [WIDE_W-1:0] S_MAX   = (WIDE_W'(1) << (WIDE_W - 1)) - WIDE_W'(1);
  localparam logic [WIDE_W-1:0] S_MIN   = WIDE_W'(1) << (WIDE_W - 1);

  // Plane store; planes_ok_q stands for the reset value until the first
  // extraction, which always rewrites all entries before any test reads them
  logic [DATA_WIDTH-1:0] plane_mem [PLANE_DEPTH];
  logic [DATA_WIDTH-1:0] rd_q;
  logic                  planes_ok_q;

  logic                  busy_q;
  logic [PLANE_AW-1:0]   cnt_q;
  logic [ELEM_W-1:0]     cx_q, cy_q, cz_q;
  logic signed [WIDE_W-1:0] limit_q;
  logic [ELEM_W-1:0]     rc;
  logic [WIDE_W-1:0]     rsh;

  // pipeline tags: read, multiply, combine
  logic       t0_v_q, t1_v_q, t2_v_q;
  logic [1:0] t0_k_q, t1_k_q, t2_k_q;
  logic       t0_l_q, t1_l_q, t2_l_q;

  logic [DATA_WIDTH-1:0] a, a_mag;
  logic [WIDE_W-1:0]     am;
  logic                  a_neg, b_neg;
  logic [ELEM_W-1:0]     b, b_mag;
  logic [WIDE_W-1:0]     mlo_q, mhi_q;
  logic                  mneg_q;
  logic [PROD_W-1:0]     p96;
  logic [WIDE_W-1:0]     prod_d, neg_p;
  logic signed [WIDE_W-1:0] prod_q;
  logic signed [WIDE_W-1:0] acc_in, acc_d, acc_q;
  logic [WIDE_W:0]       sum;
  logic                  fail_q, fail_now;
  logic                  done_q, inside_q;

  always_ff @(posedge clk_i) begin
    if (pw_i.we) plane_mem[pw_i.addr] <= pw_data_i;
    rd_q <= plane_mem[cnt_q];
  end

  // Clamp the radius and form the distance limit
  always_comb begin
    rc  = radius_i[ELEM_W-1] ? '0 : radius_i;
    rsh = WIDE_W'(rc) << FRAC_BITS;
  end

  // Multiply stage: magnitude split into two 32-bit halves
  always_comb begin
    a     = planes_ok_q ? rd_q : '0;
    a_neg = a[DATA_WIDTH-1];
    a_mag = a_neg ? (DATA_WIDTH'(0) - a) : a;
    am    = WIDE_W'(a_mag);
    unique case (t0_k_q)
      2'd0:    b = cx_q;
      2'd1:    b = cy_q;
      2'd2:    b = cz_q;
      default: b = ONE;
    endcase
    b_neg = b[ELEM_W-1] && (t0_k_q != 2'd3);
    b_mag = b_neg ? (ELEM_W'(0) - b) : b;
  end

  // Combine stage: saturate the product to signed 64 bits
  always_comb begin
    p96   = {{HALF_W{1'b0}}, mlo_q} + {mhi_q, {HALF_W{1'b0}}};
    neg_p = WIDE_W'(0) - p96[WIDE_W-1:0];
    if (mneg_q) prod_d = (p96 > LIM_NEG) ? S_MIN : neg_p;
    else        prod_d = (p96 > LIM_POS) ? S_MAX : p96[WIDE_W-1:0];
  end

  // Accumulate stage with saturating add and the plane check
  always_comb begin
    acc_in = (t2_k_q == 2'd0) ? '0 : acc_q;
    sum    = {acc_in[WIDE_W-1], acc_in} + {prod_q[WIDE_W-1], prod_q};
    if (sum[WIDE_W] != sum[WIDE_W-1]) acc_d = sum[WIDE_W] ? S_MIN : S_MAX;
    else                             acc_d = sum[WIDE_W-1:0];
    fail_now = t2_v_q && (t2_k_q == 2'd3) && (acc_d < limit_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      planes_ok_q <= 1'b0;
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      t0_v_q      <= 1'b0;
      t1_v_q      <= 1'b0;
      t2_v_q      <= 1'b0;
      fail_q      <= 1'b0;
      done_q      <= 1'b0;
      inside_q    <= 1'b0;
    end else begin
      if (pw_i.we) planes_ok_q <= 1'b1;
      t0_v_q <= busy_q;
      t1_v_q <= t0_v_q;
      t2_v_q <= t1_v_q;
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        fail_q <= 1'b0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + PLANE_AW'(1);
        if (cnt_q == PLANE_AW'(PLANE_DEPTH - 1)) busy_q <= 1'b0;
      end
      if (fail_now) fail_q <= 1'b1;
      if (t2_v_q && t2_l_q) begin
        done_q   <= 1'b1;
        inside_q <= !(fail_q || fail_now);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cx_q    <= center_x_i;
      cy_q    <= center_y_i;
      cz_q    <= center_z_i;
      limit_q <= WIDE_W'(0) - rsh;
    end
    t0_k_q <= cnt_q[1:0];
    t0_l_q <= (cnt_q == PLANE_AW'(PLANE_DEPTH - 1));
    t1_k_q <= t0_k_q;
    t1_l_q <= t0_l_q;
    t2_k_q <= t1_k_q;
    t2_l_q <= t1_l_q;
    mlo_q  <= am[HALF_W-1:0] * b_mag;
    mhi_q  <= am[WIDE_W-1:HALF_W] * b_mag;
    mneg_q <= a_neg ^ b_neg;
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign done_o   = done_q;
  assign inside_o = inside_q;

  // Pipeline checks
  a_no_store_while_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !pw_i.we) else $error("plane store written during a test");
  a_done_after_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && !t2_v_q) else $error("test done with work in flight");
  a_issue_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i && cnt_q == PLANE_AW'(PLANE_DEPTH - 1) |=> !busy_q)
    else $error("read issue ran past last component");

endmodule

`default_nettype wire

// ===== design/frustum_extract_and_sphere_cull.sv =====
// ----------------------------------------------------------------------------
// frustum_extract_and_sphere_cull
// Top level: request handshake, depth mode register, result register.
// ----------------------------------------------------------------------------
// One request beat gives one result beat. A matrix load (and an unused
// function code) goes straight to the result hold state. A sphere test
// streams the 24 stored plane components, one per cycle, through one plane
// store read port and one pipelined multiply-accumulate. Plane extraction
// is sequential per plane: 4 row reads, a capture step, three squares
// summed, a square root and four divides (a zero-length normal skips its
// divides). The result sits in an output register, so the next request is
// taken while the previous result waits on the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_extract_and_sphere_cull #(
  parameter int unsigned DATA_WIDTH = fesc_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = fesc_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fesc_in_if.sink     in_i,
  fesc_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);
  import fesc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_HOLD = 3'b100
  } tst_e;

  tst_e              state_q, state_d;
  logic              near_q;
  logic              accept;
  logic              x_start, c_start, x_done, c_done, c_inside;
  mat_wr_t           mat_wr;
  plane_wr_t         pw;
  logic [DATA_WIDTH-1:0] pw_data;
  logic              res_inside_q, res_inside_d;
  logic [FUNC_W-1:0] res_func_q, res_func_d;
  logic              out_valid_q, out_valid_d;
  logic              out_inside_q, out_inside_d;
  logic [FUNC_W-1:0] out_func_q, out_func_d;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign x_start    = accept && (in_i.func == FUNC_EXTRACT);
  assign c_start    = accept && (in_i.func == FUNC_TEST);
  assign mat_wr.we   = accept && (in_i.func == FUNC_LOAD);
  assign mat_wr.addr = in_i.element_index;

  // Request / result control
  always_comb begin
    state_d      = state_q;
    res_inside_d = res_inside_q;
    res_func_d   = res_func_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_inside_d = out_inside_q;
    out_func_d   = out_func_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_func_d = in_i.func;
          if (x_start || c_start) begin
            state_d = S_RUN;
          end else begin
            res_inside_d = 1'b0;
            state_d      = S_HOLD;
          end
        end
      end
      S_RUN: begin
        if (x_done || c_done) begin
          res_inside_d = c_done && c_inside;
          state_d      = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_inside_d = res_inside_q;
          out_func_d   = res_func_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      near_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) near_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_inside_q <= res_inside_d;
    res_func_q   <= res_func_d;
    out_inside_q <= out_inside_d;
    out_func_q   <= out_func_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.inside_res = out_inside_q;
  assign out_o.done_func  = out_func_q;

  fesc_extract #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_extract (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (x_start),
    .near_minus_one_i (near_q),
    .mat_wr_i         (mat_wr),
    .mat_data_i       (in_i.element_value),
    .pw_o             (pw),
    .pw_data_o        (pw_data),
    .done_o           (x_done)
  );

  fesc_cull #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_cull (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (c_start),
    .center_x_i (in_i.center_x),
    .center_y_i (in_i.center_y),
    .center_z_i (in_i.center_z),
    .radius_i   (in_i.radius),
    .pw_i       (pw),
    .pw_data_i  (pw_data),
    .done_o     (c_done),
    .inside_o   (c_inside)
  );

  // Control checks
  a_one_unit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(x_done && c_done)) else $error("both units finished together");
  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_done || c_done) |-> state_q == S_RUN) else $error("unit done while not running");
  a_test_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_start |=> state_q == S_RUN) else $error("sphere test not started");
  a_hold_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_HOLD && !out_valid_q |=> out_valid_q) else $error("result not moved out");

endmodule

`default_nettype wire
